@@ design/svp_pkg.sv @@
// ----------------------------------------------------------------------------
// svp_pkg
// Types and constants for the semantic version parser.
// ----------------------------------------------------------------------------
package svp_pkg;

  localparam int VAL_W = 32;
  localparam int CNT_W = 6;
  localparam logic [CNT_W-1:0] CNT_MAX = 6'd63;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_DOT  = 8'h2e;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 104;
  localparam int ADDR_W     = 4;
  localparam int APB_W      = 32;

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [VAL_W+3:0] wide_t;

  typedef enum logic [1:0] {
    REG_MAJOR = 2'd0,
    REG_MINOR = 2'd1,
    REG_PATCH = 2'd2,
    REG_NONE  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ORD_EQUAL = 2'b00,
    ORD_NEWER = 2'b01,
    ORD_OLDER = 2'b11
  } order_t;

  typedef struct packed {
    logic [1:0]       part_index;
    val_t             accum_value;
    val_t             saved_major;
    val_t             saved_minor;
    logic [CNT_W-1:0] byte_count;
    logic             digit_seen;
    logic             leading_zero;
    logic             failed;
  } parse_state_t;

  typedef struct packed {
    logic   is_valid;
    val_t   major_part;
    val_t   minor_part;
    val_t   patch_part;
    order_t order;
  } result_t;

  function automatic order_t cmp_val(input val_t a, input val_t b);
    order_t r;
    if (a == b) r = ORD_EQUAL;
    else if (a < b) r = ORD_OLDER;
    else r = ORD_NEWER;
    return r;
  endfunction

endpackage

@@ design/semantic_version_parser.sv @@
// ----------------------------------------------------------------------------
// semantic_version_parser
// Parses a dotted three-part decimal version one byte per request and
// compares it with the locally configured version.
// ----------------------------------------------------------------------------
// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      tdata: char_byte; tlast: end_of_text
// m_axis    out  m_axis_tvalid/tready      tdata: result on the final byte
// apb       in   psel/penable/pready       local_major/minor/patch at 0x0/0x4/0x8
//
// One byte per cycle unless a final byte waits for the output slot; a byte
// sits in the input register, and its parse step updates the parser state
// when it leaves that register; a final byte's result is registered then.
// Reset (rst, synchronous) clears the parser, the registers and both valids.
// A result stalled at m_axis holds only a final byte, and the input behind it;
// the other bytes of a string keep flowing.
// ----------------------------------------------------------------------------
module semantic_version_parser #(
  parameter int MAX_LEN = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] char_byte
  input  logic [svp_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] is_valid, [32:1] major_part, [64:33] minor_part, [96:65] patch_part,
  // [98:97] order, [103:99] zero
  output logic [svp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [svp_pkg::ADDR_W-1:0]    paddr,
  input  logic [svp_pkg::APB_W-1:0]     pwdata,
  output logic [svp_pkg::APB_W-1:0]     prdata,
  output logic                          pready
);
  import svp_pkg::*;

  val_t local_major, local_minor, local_patch;
  reg_idx_t reg_sel;

  logic           a_valid, a_last, a_go;
  logic [7:0]     a_byte;
  parse_state_t   st, st_next, st_step;
  result_t        res, res_next;
  logic           m_valid;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      local_major <= '0;
      local_minor <= '0;
      local_patch <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_MAJOR: local_major <= pwdata;
        REG_MINOR: local_minor <= pwdata;
        REG_PATCH: local_patch <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MAJOR: prdata = local_major;
      REG_MINOR: prdata = local_minor;
      REG_PATCH: prdata = local_patch;
      default:   prdata = '0;
    endcase
  end

  // input register advances unless a final byte waits for the output slot
  assign a_go          = a_valid && (!a_last || !m_valid || m_axis_tready);
  assign s_axis_tready = !a_valid || a_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_axis_tready) begin
      a_valid <= s_axis_tvalid;
    end
    if (s_axis_tready) begin
      a_byte <= s_axis_tdata;
      a_last <= s_axis_tlast;
    end
  end

  // parse step
  always_comb begin
    logic [CNT_W-1:0] cnt;
    logic [3:0]       d;
    wide_t            prod;
    logic             is_digit;
    st_step  = st;
    cnt      = (st.byte_count == CNT_MAX) ? st.byte_count : st.byte_count + 1'b1;
    d        = 4'(a_byte - CHAR_ZERO);
    prod     = {1'b0, st.accum_value, 3'b000} + {3'b000, st.accum_value, 1'b0} +
               {32'd0, d};
    is_digit = (a_byte >= CHAR_ZERO) && (a_byte <= CHAR_NINE);
    st_step.byte_count = cnt;
    if (st.failed || (cnt > CNT_W'(MAX_LEN))) begin
      st_step.failed = 1'b1;
    end else if (is_digit) begin
      if (st.digit_seen && st.leading_zero) begin
        st_step.failed = 1'b1;
      end else if (prod[VAL_W+3:VAL_W] != 4'd0) begin
        st_step.failed = 1'b1;
      end else begin
        if (!st.digit_seen) st_step.leading_zero = (d == 4'd0);
        st_step.accum_value = prod[VAL_W-1:0];
        st_step.digit_seen  = 1'b1;
      end
    end else if (a_byte == CHAR_DOT) begin
      if (!st.digit_seen || (st.part_index == 2'd2)) begin
        st_step.failed = 1'b1;
      end else begin
        if (st.part_index == 2'd0) st_step.saved_major = st.accum_value;
        else st_step.saved_minor = st.accum_value;
        st_step.part_index   = st.part_index + 2'd1;
        st_step.accum_value  = '0;
        st_step.digit_seen   = 1'b0;
        st_step.leading_zero = 1'b0;
      end
    end else begin
      st_step.failed = 1'b1;
    end
  end

  always_comb begin
    order_t ord;
    ord = cmp_val(st_step.saved_major, local_major);
    if (ord == ORD_EQUAL) ord = cmp_val(st_step.saved_minor, local_minor);
    if (ord == ORD_EQUAL) ord = cmp_val(st_step.accum_value, local_patch);
    res_next.is_valid = !st_step.failed && st_step.digit_seen &&
                        (st_step.part_index == 2'd2);
    if (res_next.is_valid) begin
      res_next.major_part = st_step.saved_major;
      res_next.minor_part = st_step.saved_minor;
      res_next.patch_part = st_step.accum_value;
      res_next.order      = ord;
    end else begin
      res_next.major_part = '0;
      res_next.minor_part = '0;
      res_next.patch_part = '0;
      res_next.order      = ORD_EQUAL;
    end
    st_next = a_last ? '0 : st_step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (a_go) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (a_go && a_last) begin
      m_valid <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid <= 1'b0;
    end
    if (a_go && a_last) begin
      res <= res_next;
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {5'd0, res.order, res.patch_part, res.minor_part,
                          res.major_part, res.is_valid};

  a_inv_zero : assert property (@(posedge clk) disable iff (rst)
    m_valid && !res.is_valid |-> (m_axis_tdata[98:1] == '0))
    else $error("invalid result carries nonzero fields");

  a_order_code : assert property (@(posedge clk) disable iff (rst)
    m_valid |-> (res.order != 2'b10))
    else $error("bad order code");

  a_last_out : assert property (@(posedge clk) disable iff (rst)
    a_go && a_last |=> m_valid)
    else $error("final byte produced no result");

  a_part_idx : assert property (@(posedge clk) disable iff (rst)
    st.part_index != 2'd3)
    else $error("part index overrun");

endmodule

@@ tb/semantic_version_parser_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// semantic_version_parser_tb
// Streams version strings into the parser byte by byte: well-formed versions
// near the local version and the 32-bit edges, broken strings and noise.
// Each result is checked against a software parse, over several local
// versions written through APB.
// ----------------------------------------------------------------------------
module semantic_version_parser_tb;
  import svp_pkg::*;

  localparam int MAX_LEN       = 32;
  localparam int RANDOM_BYTES  = 1600;
  localparam int PHASES        = 5;
  localparam int DRAIN_CYCLES  = 6;
  localparam int CYCLE_LIMIT   = 500000;

  typedef logic [7:0] text_t[$];

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_W-1:0]     paddr;
  logic [APB_W-1:0]      pwdata;
  logic [APB_W-1:0]      prdata;
  logic                  pready;

  semantic_version_parser #(.MAX_LEN(MAX_LEN)) uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  class version_scoreboard;
    val_t             local_ver[3];
    logic [1:0]       dots;
    val_t             accum;
    val_t             major_q;
    val_t             minor_q;
    logic [CNT_W-1:0] nbytes;
    bit               have_digit;
    bit               zero_lead;
    bit               bad;
    result_t          expected_q[$];
    int               mismatches;
    int               results_seen;
    int               valid_seen;

    function new();
      local_ver = '{default: '0};
      mismatches = 0;
      results_seen = 0;
      valid_seen = 0;
      clear();
    endfunction

    function void clear();
      dots = '0;
      accum = '0;
      major_q = '0;
      minor_q = '0;
      nbytes = '0;
      have_digit = 0;
      zero_lead = 0;
      bad = 0;
    endfunction

    function void set_local(reg_idx_t idx, val_t v);
      if (idx != REG_NONE) local_ver[idx] = v;
    endfunction

    function order_t rank(val_t a, val_t b);
      if (a == b) return ORD_EQUAL;
      return (a < b) ? ORD_OLDER : ORD_NEWER;
    endfunction

    function void note_byte(logic [7:0] c, logic last);
      val_t    d;
      result_t e;
      d = {24'd0, c - CHAR_ZERO};
      if (nbytes < CNT_MAX) nbytes++;
      if (nbytes > MAX_LEN) bad = 1;
      if (!bad) begin
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
          if (have_digit && zero_lead) begin
            bad = 1;
          end else begin
            if (!have_digit) zero_lead = (d == 0);
            if (accum > (32'hffff_ffff - d) / 10) begin
              bad = 1;
            end else begin
              accum = accum * 10 + d;
              have_digit = 1;
            end
          end
        end else if (c == CHAR_DOT) begin
          if (!have_digit || dots >= 2) begin
            bad = 1;
          end else begin
            if (dots == 0) major_q = accum;
            else minor_q = accum;
            dots++;
            accum = '0;
            have_digit = 0;
            zero_lead = 0;
          end
        end else begin
          bad = 1;
        end
      end
      if (last) begin
        e = '0;
        if (!bad && have_digit && dots == 2) begin
          e.is_valid = 1'b1;
          e.major_part = major_q;
          e.minor_part = minor_q;
          e.patch_part = accum;
          e.order = rank(major_q, local_ver[REG_MAJOR]);
          if (e.order == ORD_EQUAL) e.order = rank(minor_q, local_ver[REG_MINOR]);
          if (e.order == ORD_EQUAL) e.order = rank(accum, local_ver[REG_PATCH]);
        end
        expected_q = {expected_q, e};
        clear();
      end
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data);
      result_t e;
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("result with no request pending: %h", data);
        mismatches++;
        return;
      end
      e = expected_q.pop_front();
      if (e.is_valid) valid_seen++;
      compare("is_valid", 32'(e.is_valid), 32'(data[0]));
      compare("major_part", e.major_part, data[32:1]);
      compare("minor_part", e.minor_part, data[64:33]);
      compare("patch_part", e.patch_part, data[96:65]);
      compare("order", 32'(e.order), 32'(data[98:97]));
      compare("pad", 32'd0, 32'(data[OUT_DATA_W-1:99]));
    endfunction
  endclass

  version_scoreboard sb;
  val_t              cfg_now[3];
  int                cycles;
  int                bytes_sent;
  int                strings_sent;
  int                settings_used;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic text_t to_text(input string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t = {t, 8'(s[i])};
    return t;
  endfunction

  function automatic string pick_component(input int i);
    longint v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = cfg_now[i];
      4:          v = longint'(cfg_now[i]) + 1;
      5:          v = (cfg_now[i] == 0) ? 0 : longint'(cfg_now[i]) - 1;
      6:          v = $urandom_range(0, 999);
      7:          v = $urandom;
      8:          v = 64'd4294967290 + $urandom_range(0, 9);
      default:    v = 0;
    endcase
    return $sformatf("%0d", v);
  endfunction

  function automatic text_t make_version();
    string parts[3];
    string s;
    text_t t;
    int    m;
    int    k;
    for (int i = 0; i < 3; i++) parts[i] = pick_component(i);
    m = ($urandom_range(0, 9) < 7) ? -1 : $urandom_range(0, 6);
    k = $urandom_range(0, 2);
    if (m == 0) parts[k] = {"0", parts[k]};
    if (m == 4) parts[k] = "";
    s = {parts[0], ".", parts[1], ".", parts[2]};
    if (m == 2) s = {parts[0], ".", parts[1]};
    if (m == 3) s = {s, ".", pick_component(2)};
    t = to_text(s);
    case (m)
      1: t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(0, 255));
      5: t = t[0:$urandom_range(0, t.size() - 1)];
      6: begin
        t.delete();
        repeat ($urandom_range(1, 40)) begin
          case ($urandom_range(0, 2))
            0:       t = {t, 8'($urandom_range(0, 255))};
            1:       t = {t, 8'(CHAR_ZERO + $urandom_range(0, 9))};
            default: t = {t, CHAR_DOT};
          endcase
        end
      end
      default: ;
    endcase
    return t;
  endfunction

  // entered and left at a falling edge
  task automatic push_byte(input logic [7:0] c, input logic last, input int gap);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = c;
    s_axis_tlast = last;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_byte(c, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input text_t t);
    bit quiet;
    quiet = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < t.size(); i++) begin
      push_byte(t[i], i == t.size() - 1, quiet ? 0 : $urandom_range(0, 18));
    end
    strings_sent++;
  endtask

  task automatic apb_access(input reg_idx_t idx, input logic wr, input val_t wdata,
                            output val_t rdata);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = {idx, 2'b00};
    pwdata = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic load_local(input val_t maj, input val_t mnr, input val_t pat);
    val_t     vals[3];
    val_t     got;
    reg_idx_t idx;
    vals = '{maj, mnr, pat};
    for (int i = 0; i < 3; i++) begin
      idx = reg_idx_t'(i);
      apb_access(idx, 1'b1, vals[i], got);
      sb.set_local(idx, vals[i]);
      cfg_now[i] = vals[i];
      apb_access(idx, 1'b0, '0, got);
      if (got !== vals[i]) begin
        $error("prdata: expected %0h, got %0h", vals[i], got);
        sb.mismatches++;
      end
    end
    settings_used++;
  endtask

  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // result side: random stall before each result, with quiet stretches
  initial begin
    bit quiet;
    int gap;
    m_axis_tready = 1'b0;
    quiet = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 7) == 0) quiet = !quiet;
      gap = quiet ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        m_axis_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
      sb.check_result(m_axis_tdata);
      @(negedge clk);
    end
  end

  initial begin
    string   cases[$];
    string   s;
    text_t   t;
    val_t    junk;
    int      target;
    sb = new();
    cycles = 0;
    bytes_sent = 0;
    strings_sent = 0;
    settings_used = 0;
    cfg_now = '{default: '0};
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    load_local(1, 2, 3);
    apb_access(REG_NONE, 1'b1, $urandom, junk);

    cases = '{"1.2.3", "1.2.4", "1.2.2", "1.3.0", "1.1.9", "2.0.0", "0.9.9",
              "0.0.0", "4294967295.4294967295.4294967295", "4294967296.0.0",
              "0.0.42949672950", "01.2.3", "0.0.00", ".1.2", "1..2", "1.2.",
              "1.2.3.4", "1.2.a", "1:2.3", "1.2/3", "1.2", "1", "x"};
    foreach (cases[i]) send_text(to_text(cases[i]));
    s = "1.2.";
    repeat (29) s = {s, "3"};
    send_text(to_text(s));
    s = "";
    repeat (14) s = {s, "7.7.7"};
    send_text(to_text(s));
    t.delete();
    t = {t, 8'h00};
    send_text(t);
    t = to_text("1.2.3");
    t = {t, 8'hff};
    send_text(t);
    settle();

    target = RANDOM_BYTES / PHASES;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       load_local('0, '0, '0);
        1:       load_local('1, '1, '1);
        2:       load_local($urandom_range(0, 20), $urandom_range(0, 20),
                            $urandom_range(0, 20));
        default: load_local($urandom, $urandom, $urandom);
      endcase
      bytes_sent = 0;
      while (bytes_sent < target) send_text(make_version());
      settle();
    end

    if (sb.expected_q.size() != 0) begin
      $error("%0d results never arrived", sb.expected_q.size());
      sb.mismatches++;
    end
    $display("Checked %0d results (%0d well-formed) from %0d strings",
             sb.results_seen, sb.valid_seen, strings_sent);
    $display("under %0d local version settings, including all-zero and all-ones.",
             settings_used);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
